### rtl/core/stx_pkg.sv
// Shared types and constants of the STX/ETX packet receiver.
// Used by every module in rtl/core; depends on nothing.

package stx_pkg;

    localparam logic [7:0] STX_BYTE    = 8'h02;
    localparam logic [7:0] ETX_BYTE    = 8'h03;
    localparam logic [7:0] TYPE_CONFIG = 8'h43;   // 'C'
    localparam logic [7:0] TYPE_TIME   = 8'h54;   // 'T'
    localparam logic [7:0] TYPE_DATE   = 8'h44;   // 'D'
    localparam logic [7:0] TYPE_TDIFF  = 8'h64;   // 'd'
    localparam logic [7:0] TYPE_VCO    = 8'h56;   // 'V'

    localparam logic [5:0] MAX_PAYLOAD = 6'd61;

    localparam logic [1:0] ST_PACKET   = 2'd0;
    localparam logic [1:0] ST_BAD_TERM = 2'd1;
    localparam logic [1:0] ST_CHECKSUM = 2'd2;
    localparam logic [1:0] ST_LINE     = 2'd3;

    localparam logic [1:0] CFG_CONFIG_LEN = 2'd0;
    localparam logic [1:0] CFG_TIME_LEN   = 2'd1;
    localparam logic [1:0] CFG_TDIFF_LEN  = 2'd2;
    localparam logic [1:0] CFG_VCO_LEN    = 2'd3;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = 1;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_TYPE,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SHOW
    } bk_state_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic        frame_error;
        logic        overrun;
        logic [31:0] tick_now;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  packet_byte;
        logic        last;
        logic        line_error;
        logic [31:0] time_stamp;
        logic        stamped;
    } out_t;

    // One job for the back end: a single status word or a packet stream
    typedef struct packed {
        logic        stream;
        logic [1:0]  status;
        logic        line_error;
        logic [5:0]  length;
        logic        stamped;
        logic [31:0] stamp;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic has_stream;
    } fifo_stat_t;

endpackage

### rtl/core/stx_cmd_fifo.sv
// Two-entry job queue between the receive front end and the output back end.
// Depends on stx_pkg.

module stx_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  stx_pkg::cmd_t       push_cmd,
    input  logic                pop,
    output stx_pkg::cmd_t       head,
    output stx_pkg::fifo_stat_t stat
);

    stx_pkg::cmd_t                 entry_reg [stx_pkg::CMD_DEPTH];
    logic [stx_pkg::CMD_DEPTH-1:0] vld_reg;
    logic [stx_pkg::CMD_DEPTH-1:0] vld_next;
    logic [stx_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [stx_pkg::CMD_PTR_W-1:0] wr_ptr_next;
    logic [stx_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [stx_pkg::CMD_PTR_W-1:0] rd_ptr_next;
    logic                          any_stream;

    always_comb
    begin
        vld_next    = vld_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (pop)
        begin
            vld_next[rd_ptr_reg] = 1'b0;
            rd_ptr_next          = rd_ptr_reg + 1'b1;
        end
        if (push)
        begin
            vld_next[wr_ptr_reg] = 1'b1;
            wr_ptr_next          = wr_ptr_reg + 1'b1;
        end
    end

    always_comb
    begin
        any_stream = 1'b0;
        for (int i = 0; i < stx_pkg::CMD_DEPTH; i++)
        begin
            any_stream = any_stream | (vld_reg[i] & entry_reg[i].stream);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            vld_reg    <= vld_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head            = entry_reg[rd_ptr_reg];
    assign stat.full       = vld_reg[wr_ptr_reg];
    assign stat.empty      = !vld_reg[rd_ptr_reg];
    assign stat.has_stream = any_stream;

endmodule

### rtl/core/stx_front.sv
// Receive front end: framing, type decode, checksum and packet store writes.
// Depends on stx_pkg; feeds the job queue and the store write port.

module stx_front #(
    parameter int BUFFER_DEPTH = 64,
    parameter int AW           = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [5:0]        cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  stx_pkg::in_t      in_data,
    input  logic              fifo_full,
    input  logic              hold,
    output logic              push,
    output stx_pkg::cmd_t     push_cmd,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output logic [7:0]        wr_data
);

    stx_pkg::phase_t phase_reg, phase_next;
    logic [5:0]      bytes_left_reg, bytes_left_next;
    logic [5:0]      pkt_len_reg, pkt_len_next;
    logic [7:0]      xor_reg, xor_next;
    logic [7:0]      chk_reg, chk_next;
    logic [AW-1:0]   wr_addr_reg, wr_addr_next;
    logic [31:0]     tick_reg, tick_next;
    logic            cap_valid_reg, cap_valid_next;
    logic [5:0]      cfg_len_reg [4];

    logic            accept;
    logic            lerr;
    logic            stored;
    logic            pkt_end;
    logic [5:0]      pay;
    logic [AW-1:0]   addr_inc;

    function automatic logic [5:0] sat_len(input logic [5:0] v);
        return (v > stx_pkg::MAX_PAYLOAD) ? stx_pkg::MAX_PAYLOAD : v;
    endfunction

    assign in_ready = !fifo_full && !hold;
    assign accept   = in_valid && in_ready;
    assign lerr     = in_data.frame_error | in_data.overrun;
    assign addr_inc = (wr_addr_reg == AW'(BUFFER_DEPTH - 1)) ? '0 : wr_addr_reg + 1'b1;

    always_comb
    begin
        case (in_data.rx_byte)
            stx_pkg::TYPE_CONFIG: pay = sat_len(cfg_len_reg[stx_pkg::CFG_CONFIG_LEN]);
            stx_pkg::TYPE_TIME,
            stx_pkg::TYPE_DATE:   pay = sat_len(cfg_len_reg[stx_pkg::CFG_TIME_LEN]);
            stx_pkg::TYPE_TDIFF:  pay = sat_len(cfg_len_reg[stx_pkg::CFG_TDIFF_LEN]);
            stx_pkg::TYPE_VCO:    pay = sat_len(cfg_len_reg[stx_pkg::CFG_VCO_LEN]);
            default:              pay = 6'd0;
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        pkt_len_next    = pkt_len_reg;
        xor_next        = xor_reg;
        chk_next        = chk_reg;
        wr_addr_next    = wr_addr_reg;
        tick_next       = tick_reg;
        cap_valid_next  = cap_valid_reg;
        if (accept && !in_data.frame_error)
        begin
            case (phase_reg)
                stx_pkg::PH_HUNT:
                begin
                    if (in_data.rx_byte == stx_pkg::STX_BYTE)
                    begin
                        wr_addr_next = '0;
                        xor_next     = 8'd0;
                        phase_next   = stx_pkg::PH_TYPE;
                    end
                end
                stx_pkg::PH_TYPE:
                begin
                    xor_next       = xor_reg ^ in_data.rx_byte;
                    wr_addr_next   = addr_inc;
                    cap_valid_next = 1'b0;
                    if (in_data.rx_byte == stx_pkg::TYPE_TIME ||
                        in_data.rx_byte == stx_pkg::TYPE_DATE)
                    begin
                        tick_next      = in_data.tick_now;
                        cap_valid_next = 1'b1;
                    end
                    pkt_len_next    = pay + 6'd2;
                    bytes_left_next = pay + 6'd2;
                    phase_next      = stx_pkg::PH_BODY;
                end
                default:
                begin
                    if (bytes_left_reg >= 6'd3)
                    begin
                        xor_next = xor_reg ^ in_data.rx_byte;
                    end
                    chk_next        = in_data.rx_byte;
                    wr_addr_next    = addr_inc;
                    bytes_left_next = bytes_left_reg - 6'd1;
                    if (bytes_left_reg == 6'd1)
                    begin
                        phase_next = stx_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        stored  = accept && !in_data.frame_error && (phase_reg != stx_pkg::PH_HUNT);
        pkt_end = stored && (phase_reg != stx_pkg::PH_TYPE) && (bytes_left_reg == 6'd1);
        push    = 1'b0;
        push_cmd.stream     = 1'b0;
        push_cmd.status     = stx_pkg::ST_LINE;
        push_cmd.line_error = lerr;
        push_cmd.length     = pkt_len_reg;
        push_cmd.stamped    = 1'b0;
        push_cmd.stamp      = 32'd0;
        if (pkt_end)
        begin
            push = 1'b1;
            if (in_data.rx_byte != stx_pkg::ETX_BYTE)
            begin
                push_cmd.status = stx_pkg::ST_BAD_TERM;
            end
            else if (xor_reg == chk_reg)
            begin
                push_cmd.stream  = 1'b1;
                push_cmd.status  = stx_pkg::ST_PACKET;
                push_cmd.stamped = cap_valid_reg;
                push_cmd.stamp   = cap_valid_reg ? tick_reg : 32'd0;
            end
            else
            begin
                push_cmd.status = stx_pkg::ST_CHECKSUM;
            end
        end
        else if (accept && lerr)
        begin
            push = 1'b1;
        end
    end

    assign wr_en   = stored;
    assign wr_addr = wr_addr_reg;
    assign wr_data = in_data.rx_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= stx_pkg::PH_HUNT;
            bytes_left_reg <= '0;
            pkt_len_reg    <= '0;
            xor_reg        <= '0;
            chk_reg        <= '0;
            wr_addr_reg    <= '0;
            tick_reg       <= '0;
            cap_valid_reg  <= 1'b0;
            cfg_len_reg[stx_pkg::CFG_CONFIG_LEN] <= 6'd16;
            cfg_len_reg[stx_pkg::CFG_TIME_LEN]   <= 6'd8;
            cfg_len_reg[stx_pkg::CFG_TDIFF_LEN]  <= 6'd8;
            cfg_len_reg[stx_pkg::CFG_VCO_LEN]    <= 6'd4;
        end
        else
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            pkt_len_reg    <= pkt_len_next;
            xor_reg        <= xor_next;
            chk_reg        <= chk_next;
            wr_addr_reg    <= wr_addr_next;
            tick_reg       <= tick_next;
            cap_valid_reg  <= cap_valid_next;
            if (cfg_we)
            begin
                cfg_len_reg[cfg_index] <= cfg_data;
            end
        end
    end

endmodule

### rtl/core/stx_back.sv
// Output back end: packet store memory and the result sequencer.
// Depends on stx_pkg; takes jobs from the queue, drives the result channel.

module stx_back #(
    parameter int BUFFER_DEPTH = 64,
    parameter int AW           = 6
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  logic [AW-1:0]  wr_addr,
    input  logic [7:0]     wr_data,
    input  stx_pkg::cmd_t  head,
    input  logic           fifo_empty,
    output logic           pop,
    output logic           streaming,
    output logic           out_valid,
    input  logic           out_ready,
    output stx_pkg::out_t  out_data
);

    logic [7:0]          store_mem [BUFFER_DEPTH];
    logic [7:0]          rd_data_reg;

    stx_pkg::bk_state_t  state_reg, state_next;
    stx_pkg::cmd_t       cmd_reg, cmd_next;
    logic [5:0]          k_reg, k_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic                final_word;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (state_reg == stx_pkg::BK_READ)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    assign final_word = !cmd_reg.stream || (k_reg == cmd_reg.length - 6'd1);

    // Next state
    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        k_next       = k_reg;
        rd_addr_next = rd_addr_reg;
        case (state_reg)
            stx_pkg::BK_IDLE:
            begin
                if (!fifo_empty)
                begin
                    cmd_next     = head;
                    k_next       = 6'd0;
                    rd_addr_next = '0;
                    state_next   = head.stream ? stx_pkg::BK_READ : stx_pkg::BK_SHOW;
                end
            end
            stx_pkg::BK_READ:
            begin
                state_next = stx_pkg::BK_SHOW;
            end
            stx_pkg::BK_SHOW:
            begin
                if (out_ready)
                begin
                    if (final_word)
                    begin
                        state_next = stx_pkg::BK_IDLE;
                    end
                    else
                    begin
                        k_next       = k_reg + 6'd1;
                        rd_addr_next = (rd_addr_reg == AW'(BUFFER_DEPTH - 1)) ?
                                       '0 : rd_addr_reg + 1'b1;
                        state_next   = stx_pkg::BK_READ;
                    end
                end
            end
            default:
            begin
                state_next = stx_pkg::BK_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        pop                 = (state_reg == stx_pkg::BK_IDLE) && !fifo_empty;
        streaming           = (state_reg != stx_pkg::BK_IDLE) && cmd_reg.stream;
        out_valid           = (state_reg == stx_pkg::BK_SHOW);
        out_data.status     = cmd_reg.status;
        out_data.packet_byte = cmd_reg.stream ? rd_data_reg : 8'd0;
        out_data.last       = final_word;
        out_data.line_error = cmd_reg.line_error;
        out_data.time_stamp = cmd_reg.stamp;
        out_data.stamped    = cmd_reg.stamped;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= stx_pkg::BK_IDLE;
            k_reg       <= '0;
            rd_addr_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            rd_addr_reg <= rd_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

### rtl/core/stx_etx_packet_receiver_core.sv
// Top level of the STX/ETX packet receiver with XOR checksum.
// Depends on stx_pkg, stx_front, stx_cmd_fifo and stx_back.

// The receiver takes one serial byte per input word with its frame-error and
// overrun flags, hunts for STX, decodes the type byte into a payload length
// from the four length registers (saturated at 61), writes type, payload,
// checksum and ETX into a packet store and checks terminator and XOR sum at
// the end. A good packet comes out as one result word per stored byte (type,
// payload, checksum), a bad one as a single status word, and a byte with a
// line error and nothing else to report gives a line-error status word. The
// front end takes a byte whenever it is ready; a finished job goes into a
// two-entry queue, and the back end passes each status word through its idle
// and show states, so a run of line-error bytes or an output stall can fill
// the queue and hold input off until an entry drains. While a good packet is
// waiting in the queue or being streamed, input is held off, because the
// stream reads the store that the next packet would overwrite: the back end
// pops the job in its idle state, then reads and presents each result word
// in a read state and a show state, waiting through any output stall. There is no clearing
// pass after reset. Write the length registers only while the block is idle.

module stx_etx_packet_receiver_core #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [5:0]     cfg_data,
    input  logic           in_valid,
    output logic           in_ready,
    input  stx_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output stx_pkg::out_t  out_data
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic                 push;
    stx_pkg::cmd_t        push_cmd;
    logic                 pop;
    stx_pkg::cmd_t        head;
    stx_pkg::fifo_stat_t  fifo_stat;
    logic                 streaming;
    logic                 hold;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;

    // Hold input while a good packet still needs the store
    assign hold = fifo_stat.has_stream | streaming;

    stx_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .fifo_full (fifo_stat.full),
        .hold      (hold),
        .push      (push),
        .push_cmd  (push_cmd),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    stx_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (fifo_stat)
    );

    stx_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .head       (head),
        .fifo_empty (fifo_stat.empty),
        .pop        (pop),
        .streaming  (streaming),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

### tb/testbench.sv
// Self-checking testbench for stx_etx_packet_receiver_core: drives serial bytes,
// predicts every result word and checks each one as it leaves the block.
// Depends on stx_pkg and the receiver RTL; reads no files.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int HOLD_CYCLES  = 400;   // long output hold-off in the pressure test
    localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake before giving up
    localparam int SETTLE       = 20;    // trailing cycles once nothing is expected
    localparam logic [7:0] UNKNOWN_TYPE = 8'hFF;

    // How a generated packet is spoilt, if at all
    typedef enum {
        PKT_GOOD,
        PKT_BAD_SUM,
        PKT_BAD_END,
        PKT_NOISY,
        PKT_SHORT
    } pkt_flaw_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [5:0]    cfg_data;
    logic          in_valid;
    logic          in_ready;
    stx_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    stx_pkg::out_t out_data;

    // Shadow of the length registers, reset values as in the block
    logic [5:0] len_reg [4] = '{6'd16, 6'd8, 6'd8, 6'd4};

    // Predicted receiver state
    stx_pkg::phase_t rx_phase = stx_pkg::PH_HUNT;
    int         body_left = 0;
    int         pkt_len   = 0;
    logic [7:0] xor_sum   = '0;
    int         wr_idx    = 0;
    logic [7:0] pkt_store [DEPTH];
    logic [31:0] tick_held = '0;
    logic       tick_ok   = 1'b0;

    stx_pkg::out_t expected_words [$];
    int         errors       = 0;
    int         items_sent   = 0;
    int         send_idle_pct  = 0;
    int         recv_stall_pct = 0;
    int         hold_seq     = 0;
    int         hold_seen    = 0;
    int         hold_left    = 0;
    int         quiet_cycles = 0;

    stx_etx_packet_receiver_core #(
        .BUFFER_DEPTH(DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Payload length that a type byte selects, saturated at the largest
    // packet the store can stream
    function automatic int payload_len(input logic [7:0] kind);
        logic [5:0] raw;
        case (kind)
            stx_pkg::TYPE_CONFIG: raw = len_reg[stx_pkg::CFG_CONFIG_LEN];
            stx_pkg::TYPE_TIME,
            stx_pkg::TYPE_DATE:   raw = len_reg[stx_pkg::CFG_TIME_LEN];
            stx_pkg::TYPE_TDIFF:  raw = len_reg[stx_pkg::CFG_TDIFF_LEN];
            stx_pkg::TYPE_VCO:    raw = len_reg[stx_pkg::CFG_VCO_LEN];
            default:              return 0;
        endcase
        return (raw > stx_pkg::MAX_PAYLOAD) ? int'(stx_pkg::MAX_PAYLOAD) : int'(raw);
    endfunction

    function automatic stx_pkg::out_t status_word(input logic [1:0] code,
                                                  input logic lerr);
        stx_pkg::out_t r;
        r            = '0;
        r.status     = code;
        r.line_error = lerr;
        return r;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        pkt_store[wr_idx % DEPTH] = b;
        wr_idx = (wr_idx + 1) & 63;
    endfunction

    // Advance the predicted receiver by one accepted word and queue the
    // result words that it causes
    function automatic void predict_word(input stx_pkg::in_t w);
        stx_pkg::out_t fresh [$];
        stx_pkg::out_t r;
        logic lerr;
        int   ci;
        lerr = w.frame_error | w.overrun;
        // A framing error discards the byte: no state moves
        if (!w.frame_error) begin
            case (rx_phase)
                stx_pkg::PH_HUNT:
                begin
                    if (w.rx_byte == stx_pkg::STX_BYTE) begin
                        wr_idx   = 0;
                        xor_sum  = '0;
                        rx_phase = stx_pkg::PH_TYPE;
                    end
                end
                stx_pkg::PH_TYPE:
                begin
                    xor_sum ^= w.rx_byte;
                    store_byte(w.rx_byte);
                    tick_ok = 1'b0;
                    if (w.rx_byte == stx_pkg::TYPE_TIME ||
                        w.rx_byte == stx_pkg::TYPE_DATE) begin
                        tick_held = w.tick_now;
                        tick_ok   = 1'b1;
                    end
                    // payload plus checksum plus terminator still to come
                    pkt_len   = payload_len(w.rx_byte) + 2;
                    body_left = pkt_len;
                    rx_phase  = stx_pkg::PH_BODY;
                end
                default:
                begin
                    // only payload bytes enter the sum; the unused fourth
                    // phase behaves like the body
                    if (body_left >= 3)
                        xor_sum ^= w.rx_byte;
                    store_byte(w.rx_byte);
                    body_left = (body_left - 1) & 63;
                    if (body_left == 0) begin
                        rx_phase = stx_pkg::PH_HUNT;
                        ci = ((pkt_len - 1) & 63) % DEPTH;
                        if (w.rx_byte != stx_pkg::ETX_BYTE)
                            fresh.push_back(status_word(stx_pkg::ST_BAD_TERM, lerr));
                        else if (xor_sum == pkt_store[ci]) begin
                            for (int k = 0; k < pkt_len && k < 63; k++) begin
                                r             = '0;
                                r.status      = stx_pkg::ST_PACKET;
                                r.packet_byte = pkt_store[k % DEPTH];
                                r.line_error  = lerr;
                                r.time_stamp  = tick_ok ? tick_held : '0;
                                r.stamped     = tick_ok;
                                fresh.push_back(r);
                            end
                        end
                        else
                            fresh.push_back(status_word(stx_pkg::ST_CHECKSUM, lerr));
                    end
                end
            endcase
        end
        // a line error alone still gets reported
        if (fresh.size() == 0 && lerr)
            fresh.push_back(status_word(stx_pkg::ST_LINE, 1'b1));
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i])
            expected_words.push_back(fresh[i]);
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    function automatic stx_pkg::in_t make_word(input logic [7:0] b, input logic fe,
                                               input logic ov);
        stx_pkg::in_t w;
        w.rx_byte     = b;
        w.frame_error = fe;
        w.overrun     = ov;
        w.tick_now    = $urandom;
        return w;
    endfunction

    // Offer one word and hold it until taken. Valid stays high on return so
    // that a following word can go out back to back. Predict on offering:
    // the word is bound to be the next one accepted.
    task automatic send_word(input stx_pkg::in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        predict_word(w);
        items_sent++;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drop valid, wait for every expected word, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Write all four length registers while the block is idle
    task automatic set_lengths(input logic [5:0] c_len, input logic [5:0] t_len,
                               input logic [5:0] d_len, input logic [5:0] v_len);
        logic [5:0] vals [4];
        vals = '{c_len, t_len, d_len, v_len};
        wait_drained();
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            len_reg[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(5))
            0:       return stx_pkg::TYPE_CONFIG;
            1:       return stx_pkg::TYPE_TIME;
            2:       return stx_pkg::TYPE_DATE;
            3:       return stx_pkg::TYPE_TDIFF;
            4:       return stx_pkg::TYPE_VCO;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Send STX, type, payload, checksum and ETX, spoilt as the flaw says
    task automatic send_packet(input logic [7:0] kind, input pkt_flaw_t flaw);
        logic [7:0] body [$];
        logic [7:0] sum;
        logic [7:0] b;
        logic       noisy;
        noisy = (flaw == PKT_NOISY);
        body.push_back(kind);
        sum = kind;
        repeat (payload_len(kind)) begin
            b = 8'($urandom_range(255));
            body.push_back(b);
            sum ^= b;
        end
        if (flaw == PKT_BAD_SUM)
            sum ^= 8'd1 << $urandom_range(7);
        body.push_back(sum);
        if (flaw == PKT_BAD_END) begin
            b = 8'($urandom_range(255));
            body.push_back(b == stx_pkg::ETX_BYTE ? ~b : b);
        end
        else if (flaw != PKT_SHORT)
            body.push_back(stx_pkg::ETX_BYTE);   // a short packet eats the next STX
        send_word(make_word(stx_pkg::STX_BYTE, 1'b0, noisy && $urandom_range(3) == 0));
        foreach (body[i]) begin
            // noisy packets carry discarded framing-error bytes and overruns
            if (noisy && $urandom_range(3) == 0)
                send_word(make_word(8'($urandom_range(255)), 1'b1,
                                    1'($urandom_range(1))));
            send_word(make_word(body[i], 1'b0, noisy && $urandom_range(2) == 0));
        end
    endtask

    // Mostly well-formed packets with random content, some spoilt ones and
    // bursts of line noise
    task automatic run_random(input int target, input int send_pct, input int recv_pct);
        int        start;
        int        roll;
        pkt_flaw_t flaw;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start = items_sent;
        while (items_sent - start < target) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                repeat ($urandom_range(1, 4))
                    send_word(make_word(8'($urandom_range(255)),
                                        $urandom_range(7) == 0, $urandom_range(7) == 0));
            end
            else begin
                roll = $urandom_range(99);
                if (roll < 60)      flaw = PKT_GOOD;
                else if (roll < 70) flaw = PKT_BAD_SUM;
                else if (roll < 78) flaw = PKT_BAD_END;
                else if (roll < 93) flaw = PKT_NOISY;
                else                flaw = PKT_SHORT;
                send_packet(pick_type(), flaw);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Registers untouched since reset: their reset lengths must apply
    task automatic test_reset_lengths();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_packet(stx_pkg::TYPE_VCO, PKT_GOOD);
        send_packet(stx_pkg::TYPE_TIME, PKT_GOOD);
        send_packet(stx_pkg::TYPE_CONFIG, PKT_GOOD);
        send_packet(stx_pkg::TYPE_TDIFF, PKT_GOOD);
    endtask

    // Line errors while hunting: a discarded STX, an overrun on an ignored
    // byte, and both flags at once
    task automatic test_line_errors();
        send_word(make_word(stx_pkg::STX_BYTE, 1'b1, 1'b0));
        send_word(make_word(stx_pkg::TYPE_CONFIG, 1'b0, 1'b1));
        send_word(make_word(8'hFF, 1'b1, 1'b1));
    endtask

    // One empty packet of every type; tick extremes on the stamped types,
    // a discarded byte inside one packet and an overrun on a terminator
    task automatic test_packet_types();
        logic [7:0]   kinds [6];
        stx_pkg::in_t w;
        kinds = '{stx_pkg::TYPE_CONFIG, stx_pkg::TYPE_TIME, stx_pkg::TYPE_DATE,
                  stx_pkg::TYPE_TDIFF, stx_pkg::TYPE_VCO, UNKNOWN_TYPE};
        set_lengths(6'd0, 6'd0, 6'd0, 6'd0);
        foreach (kinds[i]) begin
            send_word(make_word(stx_pkg::STX_BYTE, 1'b0, 1'b0));
            w = make_word(kinds[i], 1'b0, 1'b0);
            if (kinds[i] == stx_pkg::TYPE_TIME) w.tick_now = '1;
            if (kinds[i] == stx_pkg::TYPE_DATE) w.tick_now = '0;
            send_word(w);
            if (kinds[i] == stx_pkg::TYPE_TIME)
                send_word(make_word(stx_pkg::ETX_BYTE, 1'b1, 1'b0));
            // with no payload the checksum is the type byte itself
            send_word(make_word(kinds[i], 1'b0, 1'b0));
            send_word(make_word(stx_pkg::ETX_BYTE, 1'b0, kinds[i] == UNKNOWN_TYPE));
        end
    endtask

    // Random traffic over several length settings and idling mixes,
    // including lengths above the saturation point
    task automatic test_random_traffic();
        set_lengths(6'd1, 6'd2, 6'd3, 6'd5);
        run_random(25, 52, 0);
        set_lengths(6'd63, 6'd0, 6'd62, 6'd2);
        run_random(25, 0, 52);
        set_lengths(6'd7, 6'd3, 6'd0, 6'd61);
        run_random(20, 23, 23);
    endtask

    // Hold the output off for a long stretch while input keeps coming, so
    // the job queue fills and input stalls; then pause until drained
    task automatic test_backpressure();
        set_lengths(6'd4, 6'd4, 6'd4, 6'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_seq++;
        repeat (3) send_packet(pick_type(), PKT_BAD_SUM);
        repeat (2) send_packet(pick_type(), PKT_BAD_END);
        send_packet(stx_pkg::TYPE_TIME, PKT_GOOD);
        send_packet(stx_pkg::TYPE_VCO, PKT_GOOD);
        wait_drained();
        repeat (3) send_packet(pick_type(), PKT_GOOD);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Random output stalls, overridden by a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void compare_field(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Check each accepted word against the oldest expectation
    always @(posedge clk)
    begin : check_results
        stx_pkg::out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
                errors++;
            end
            else begin
                want = expected_words.pop_front();
                compare_field("status",      32'(want.status),
                              32'(out_data.status));
                compare_field("packet_byte", 32'(want.packet_byte),
                              32'(out_data.packet_byte));
                compare_field("last",        32'(want.last),
                              32'(out_data.last));
                compare_field("line_error",  32'(want.line_error),
                              32'(out_data.line_error));
                compare_field("time_stamp",  want.time_stamp,
                              out_data.time_stamp);
                compare_field("stamped",     32'(want.stamped),
                              32'(out_data.stamped));
            end
        end
    end

    // Give up when nothing moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d words still expected",
                     $time, QUIET_LIMIT, expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_lengths();
        test_line_errors();
        test_packet_types();
        test_random_traffic();
        test_backpressure();
        wait_drained();

        if (errors == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
rtl/core/stx_pkg.sv
rtl/core/stx_cmd_fifo.sv
rtl/core/stx_front.sv
rtl/core/stx_back.sv
rtl/core/stx_etx_packet_receiver_core.sv
tb/testbench.sv
